// ===== design/pa3_pkg.sv =====
package pa3_pkg;

	localparam int NRM_W  = 16;
	localparam int SUM_W  = 64;
	localparam int AREA_W = 48;
	localparam int QDEPTH = 4;
	// dividend of the scale divide: sqrt result (30 bits) shifted up by 15
	localparam int DIV_W  = 45;

	localparam logic [1:0] AX_X = 2'd0;
	localparam logic [1:0] AX_Y = 2'd1;
	localparam logic [1:0] AX_Z = 2'd2;

	typedef logic signed [NRM_W-1:0] nrm_t;

	typedef struct packed {
		nrm_t [2:0] nrm;
		logic [1:0] axis;
		logic       few;
	} pinfo_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		pinfo_t           info;
	} job_t;

	typedef struct packed {
		logic [AREA_W-1:0] area;
		logic              degen;
		logic              sat;
	} res_t;

	function automatic logic [NRM_W-1:0] nrm_abs(input nrm_t n);
		nrm_abs = n[NRM_W-1] ? NRM_W'(-n) : NRM_W'(n);
	endfunction

	function automatic nrm_t nrm_pick(input pinfo_t info);
		case (info.axis)
			AX_X:    nrm_pick = info.nrm[0];
			AX_Y:    nrm_pick = info.nrm[1];
			default: nrm_pick = info.nrm[2];
		endcase
	endfunction

endpackage

// ===== design/pa3_fifo.sv =====
module pa3_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic         empty,
	output logic [W-1:0] rdata
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

// ===== design/pa3_front.sv =====
module pa3_front import pa3_pkg::*; #(
	parameter int MAX_VERTICES = 256,
	parameter int COORD_BITS   = 24
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [119:0]              s_tdata,
	input  logic                      s_tlast,
	output logic                      push_valid,
	input  logic                      push_ready,
	output logic [4*COORD_BITS-1:0]   push_edge,
	output logic                      push_fin,
	output pinfo_t                    push_info
);
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int FW = (COORD_BITS > 24) ? COORD_BITS : 24;
	localparam int PJ = 2 * COORD_BITS;

	typedef logic [2:0][COORD_BITS-1:0] vtx_t;

	// projection onto the two kept axes, u in the low half
	function automatic logic [PJ-1:0] proj(input vtx_t p, input logic [1:0] ax);
		case (ax)
			AX_X:    proj = {p[2], p[1]};
			AX_Y:    proj = {p[0], p[2]};
			default: proj = {p[1], p[0]};
		endcase
	endfunction

	function automatic logic [1:0] drop_axis(input nrm_t [2:0] n);
		logic [NRM_W-1:0] ax, ay, az;
		ax = nrm_abs(n[0]);
		ay = nrm_abs(n[1]);
		az = nrm_abs(n[2]);
		if (ax > ay) begin
			drop_axis = (ax > az) ? AX_X : AX_Z;
		end else begin
			drop_axis = (ay > az) ? AX_Y : AX_Z;
		end
	endfunction

	logic [CW-1:0]   cnt_q, cnt_n;
	vtx_t            start_q, prev_q, cur, start_n;
	nrm_t [2:0]      nrm_q, nrm_in, nrm_n;
	logic [1:0]      axis_q, axis_n;
	logic            hv_q, need_a_q, need_b_q;
	logic [4*COORD_BITS-1:0] ea_q, eb_q;
	pinfo_t          info_q;
	logic            first, acc, push_ok;
	logic [FW-1:0]   fe;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			fe        = FW'(s_tdata[i*24 +: 24]);
			cur[i]    = fe[COORD_BITS-1:0];
			nrm_in[i] = s_tdata[72 + i*16 +: 16];
		end
	end

	assign first   = (cnt_q == '0);
	assign nrm_n   = first ? nrm_in : nrm_q;
	assign axis_n  = first ? drop_axis(nrm_in) : axis_q;
	assign start_n = first ? cur : start_q;
	assign cnt_n   = (cnt_q == CW'(MAX_VERTICES)) ? cnt_q : cnt_q + 1'b1;

	assign s_tready   = !hv_q;
	assign acc        = s_tvalid && s_tready;
	assign push_valid = hv_q;
	assign push_ok    = push_valid && push_ready;
	assign push_edge  = need_a_q ? ea_q : eb_q;
	assign push_fin   = !need_a_q;
	assign push_info  = info_q;

	always_ff @(posedge clk) begin
		if (acc) begin
			prev_q  <= cur;
			start_q <= start_n;
			nrm_q   <= nrm_n;
			axis_q  <= axis_n;
			ea_q    <= {proj(cur, axis_q), proj(prev_q, axis_q)};
			eb_q    <= {proj(start_n, axis_n), proj(cur, axis_n)};
			info_q  <= '{nrm: nrm_n, axis: axis_n, few: (cnt_n < CW'(3))};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			hv_q     <= 1'b0;
			need_a_q <= 1'b0;
			need_b_q <= 1'b0;
		end else begin
			if (acc) begin
				cnt_q    <= s_tlast ? '0 : cnt_n;
				hv_q     <= !first || s_tlast;
				need_a_q <= !first;
				need_b_q <= s_tlast;
			end else if (push_ok) begin
				if (need_a_q) begin
					need_a_q <= 1'b0;
					hv_q     <= need_b_q;
				end else begin
					need_b_q <= 1'b0;
					hv_q     <= 1'b0;
				end
			end
		end
	end
endmodule

// ===== design/pa3_back.sv =====
module pa3_back import pa3_pkg::*; #(
	parameter int COORD_BITS = 24
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    pop_valid,
	output logic                    pop_ready,
	input  logic [4*COORD_BITS-1:0] pop_edge,
	input  logic                    pop_fin,
	input  pinfo_t                  pop_info,
	input  logic                    fin_busy,
	output logic                    job_start,
	output job_t                    job
);
	localparam int CB = COORD_BITS;

	logic                    v_s1, fin_s1, v_s2, fin_s2;
	logic [4*CB-1:0]         edge_s1;
	pinfo_t                  info_s1, info_s2;
	logic signed [SUM_W-1:0] p_s2, q_s2;
	logic [SUM_W-1:0]        sum_q, total;
	logic signed [CB-1:0]    au, av, bu, bv;
	logic                    take;

	assign au = edge_s1[CB-1:0];
	assign av = edge_s1[2*CB-1:CB];
	assign bu = edge_s1[3*CB-1:2*CB];
	assign bv = edge_s1[4*CB-1:3*CB];

	// hold off while a closing edge is in flight or the finisher is busy
	assign pop_ready = !(v_s1 && fin_s1) && !(v_s2 && fin_s2) && !fin_busy;
	assign take      = pop_valid && pop_ready;

	assign total     = sum_q + SUM_W'(p_s2) - SUM_W'(q_s2);
	assign job_start = v_s2 && fin_s2;
	assign job       = '{sum: total, info: info_s2};

	always_ff @(posedge clk) begin
		if (take) begin
			edge_s1 <= pop_edge;
			info_s1 <= pop_info;
			fin_s1  <= pop_fin;
		end
		if (v_s1) begin
			p_s2    <= SUM_W'(au * bv);
			q_s2    <= SUM_W'(bu * av);
			info_s2 <= info_s1;
			fin_s2  <= fin_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			sum_q <= '0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
			if (v_s2) begin
				sum_q <= fin_s2 ? '0 : total;
			end
		end
	end
endmodule

// ===== design/pa3_finish.sv =====
module pa3_finish import pa3_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  job_t job,
	output logic busy,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_NSQ  = 3'd1;
	localparam logic [2:0] ST_CHK  = 3'd2;
	localparam logic [2:0] ST_SQRT = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_MLO  = 3'd5;
	localparam logic [2:0] ST_MHI  = 3'd6;
	localparam logic [2:0] ST_OUT  = 3'd7;
	localparam int DCW = $clog2(DIV_W);
	localparam logic [SUM_W-1:0] LIM = SUM_W'(1) << (AREA_W - 1);

	logic [2:0]       st_q;
	pinfo_t           info_q;
	logic [SUM_W-1:0] mag_q, x_q, r_q, one_q, lo_q, hi_q;
	logic [SUM_W-1:0] trial, r_n, qv, negq;
	logic             neg_q, deg_q;
	logic [31:0]      nsq_q;
	logic [DIV_W-1:0] dv_q;
	logic [NRM_W-1:0] rem_q, dab_q;
	logic [NRM_W:0]   shl;
	logic             qbit;
	logic [DCW-1:0]   dcnt_q;
	nrm_t             nd_in;

	assign busy      = (st_q != ST_IDLE);
	assign res_valid = (st_q == ST_OUT);
	assign nd_in     = nrm_pick(job.info);

	assign trial = r_q + one_q;
	assign r_n   = (x_q >= trial) ? (r_q >> 1) + one_q : (r_q >> 1);
	assign shl   = {rem_q, dv_q[DIV_W-1]};
	assign qbit  = (shl >= {1'b0, dab_q});

	// round half up on the low partial product, 30 fraction bits dropped
	assign qv   = (hi_q << 2) + ((lo_q + (SUM_W'(1) << 29)) >> 30);
	assign negq = SUM_W'(0) - qv;

	always_comb begin
		res = '0;
		if (deg_q) begin
			res.degen = 1'b1;
		end else if (neg_q) begin
			if (qv > LIM) begin
				res.area = AREA_W'(SUM_W'(0) - LIM);
				res.sat  = 1'b1;
			end else begin
				res.area = negq[AREA_W-1:0];
			end
		end else begin
			if (qv > LIM - 1'b1) begin
				res.area = AREA_W'(LIM - 1'b1);
				res.sat  = 1'b1;
			end else begin
				res.area = qv[AREA_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				info_q <= job.info;
				mag_q  <= job.sum[SUM_W-1] ? SUM_W'(0) - job.sum : job.sum;
				neg_q  <= job.sum[SUM_W-1] ^ nd_in[NRM_W-1];
			end
			ST_NSQ: begin
				nsq_q <= 32'(info_q.nrm[0] * info_q.nrm[0])
					+ 32'(info_q.nrm[1] * info_q.nrm[1])
					+ 32'(info_q.nrm[2] * info_q.nrm[2]);
				dab_q <= nrm_abs(nrm_pick(info_q));
			end
			ST_CHK: begin
				deg_q <= info_q.few || (nsq_q == '0);
				x_q   <= SUM_W'({nsq_q, 28'b0});
				r_q   <= '0;
				one_q <= SUM_W'(1) << 62;
			end
			ST_SQRT: begin
				if (x_q >= trial) begin
					x_q <= x_q - trial;
				end
				r_q    <= r_n;
				one_q  <= one_q >> 2;
				dv_q   <= DIV_W'({r_n[29:0], 15'b0});
				rem_q  <= '0;
				dcnt_q <= '0;
			end
			ST_DIV: begin
				rem_q  <= qbit ? NRM_W'(shl - {1'b0, dab_q}) : shl[NRM_W-1:0];
				dv_q   <= {dv_q[DIV_W-2:0], qbit};
				dcnt_q <= dcnt_q + 1'b1;
			end
			ST_MLO: begin
				lo_q <= SUM_W'(mag_q[31:0]) * SUM_W'(dv_q[31:0]);
			end
			ST_MHI: begin
				hi_q <= SUM_W'(mag_q[63:32]) * SUM_W'(dv_q[31:0]);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			case (st_q)
				ST_IDLE: if (start) st_q <= ST_NSQ;
				ST_NSQ:  st_q <= ST_CHK;
				ST_CHK:  st_q <= (info_q.few || (nsq_q == '0)) ? ST_OUT : ST_SQRT;
				ST_SQRT: if (one_q == SUM_W'(1)) st_q <= ST_DIV;
				ST_DIV:  if (dcnt_q == DCW'(DIV_W - 1)) st_q <= ST_MLO;
				ST_MLO:  st_q <= ST_MHI;
				ST_MHI:  st_q <= ST_OUT;
				ST_OUT:  if (res_ready) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== design/polygon_area_3d_core.sv =====
// Signed area of a planar polygon in 3D. Vertices come in one beat each on the
// slave side (tlast on the final vertex); the plane normal is taken from the first
// beat of a polygon and ignored afterwards. One result beat leaves per polygon:
// area with 24 fraction bits, saturated to 48 bits, plus degenerate (fewer than
// three vertices or zero normal) and saturated flags in tuser. The front end takes
// no vertex while the edge closed by the previous one waits to issue (a polygon's
// first vertex closes none), and a final vertex also issues the closing edge as a
// second job into a 4-entry queue. The back end retires one edge per cycle through
// a two-stage multiply/accumulate pipe unless held off by a closing edge in flight
// or a busy finisher. The finisher then takes each polygon (bit-serial 32-step
// square root, 45-step restoring divide, two 32x32 partial products), during which
// the back end stops draining the queue but the front end keeps loading vertices
// of the next polygon until the queue fills. A waiting result sits in the output
// register and does not block either side until the next finish is due.
module polygon_area_3d_core import pa3_pkg::*; #(
	parameter int MAX_VERTICES = 256,
	parameter int COORD_BITS   = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// x_coord[23:0], y_coord[47:24], z_coord[71:48],
	// normal_x[87:72], normal_y[103:88], normal_z[119:104]
	input  logic [119:0] s_tdata,
	input  logic         s_tlast,  // last_vertex
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [47:0]  m_tdata,  // area[47:0]
	output logic [1:0]   m_tuser   // degenerate[0], saturated[1]
);
	localparam int EW = 4 * COORD_BITS;
	localparam int QW = EW + 1 + $bits(pinfo_t);

	// front end to queue
	logic          push_valid, push_ready, push_fin;
	logic [EW-1:0] push_edge;
	pinfo_t        push_info;
	// queue to back end
	logic          q_full, q_empty, pop_ready;
	logic [QW-1:0] q_rdata;
	// back end to finisher
	logic          job_start, fin_busy;
	job_t          job;
	// finisher to output register
	logic          res_valid, res_ready;
	res_t          res;
	logic          out_v_q;
	res_t          out_q;

	pa3_front #(
		.MAX_VERTICES (MAX_VERTICES),
		.COORD_BITS   (COORD_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_edge  (push_edge),
		.push_fin   (push_fin),
		.push_info  (push_info)
	);

	assign push_ready = !q_full;

	pa3_fifo #(
		.W     (QW),
		.DEPTH (QDEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push_valid),
		.wdata  ({push_edge, push_fin, push_info}),
		.full   (q_full),
		.pop    (pop_ready),
		.empty  (q_empty),
		.rdata  (q_rdata)
	);

	pa3_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (!q_empty),
		.pop_ready (pop_ready),
		.pop_edge  (q_rdata[QW-1 -: EW]),
		.pop_fin   (q_rdata[$bits(pinfo_t)]),
		.pop_info  (q_rdata[$bits(pinfo_t)-1:0]),
		.fin_busy  (fin_busy),
		.job_start (job_start),
		.job       (job)
	);

	pa3_finish u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (job_start),
		.job       (job),
		.busy      (fin_busy),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// output register: refilled in the same cycle it drains
	assign res_ready = !out_v_q || m_tready;

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (res_ready) begin
			out_v_q <= res_valid;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q.area;
	assign m_tuser  = {out_q.sat, out_q.degen};

`ifndef ASSERT_OFF
	// a closing edge only reaches the finisher when it is free
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		job_start |-> !fin_busy)
		else $error("finisher started while busy");

	// a finished result is held until the output register takes it
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped by finisher");

	// a degenerate polygon reports zero area and no clipping
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata == '0) && !m_tuser[1])
		else $error("degenerate result with nonzero area");
`endif
endmodule
